[rtl/buddy_block_allocator_macros.svh]
// Assertion macros shared by the buddy block allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define BBA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_RST(lbl, prop)
`endif
`endif

[rtl/bba_pkg.sv]
// Shared constants and types of the buddy block allocator.
package bba_pkg;
  localparam int ADDR_BITS = 15;
  localparam int ORD_W = 4;
  localparam int DEF_ORDER_COUNT = 16;
  localparam int DEF_UNIT_ORDER = 5;
  localparam logic [3:0] POOL_ORDER_RST = 4'd15;
  localparam logic [7:0] HEADER_RST = 8'd32;
  localparam logic REG_POOL_ORDER = 1'b0;
  localparam logic REG_HEADER = 1'b1;
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;
  localparam logic [1:0] ST_NOT_OWNER = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [ADDR_BITS-1:0] offset;
  } res_t;
endpackage

[rtl/bba_desc_mem.sv]
// Unit descriptor memories: order and free tag, next link, prev link.
module bba_desc_mem #(
  parameter int UB = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [UB-1:0] rd_addr_i,
  output logic [4:0]    rd_meta_o,
  output logic [UB:0]   rd_next_o,
  output logic [UB:0]   rd_prev_o,
  input  logic          meta_we_i,
  input  logic [UB-1:0] meta_addr_i,
  input  logic [4:0]    meta_wdata_i,
  input  logic          next_we_i,
  input  logic [UB-1:0] next_addr_i,
  input  logic [UB:0]   next_wdata_i,
  input  logic          prev_we_i,
  input  logic [UB-1:0] prev_addr_i,
  input  logic [UB:0]   prev_wdata_i
);
  localparam int UNITS = 1 << UB;

  logic [4:0]  meta_mem [UNITS];
  logic [UB:0] next_mem [UNITS];
  logic [UB:0] prev_mem [UNITS];

  always_ff @(posedge clk_i) begin
    if (meta_we_i) begin
      meta_mem[meta_addr_i] <= meta_wdata_i;
    end
    if (next_we_i) begin
      next_mem[next_addr_i] <= next_wdata_i;
    end
    if (prev_we_i) begin
      prev_mem[prev_addr_i] <= prev_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_meta_o <= meta_mem[rd_addr_i];
      rd_next_o <= next_mem[rd_addr_i];
      rd_prev_o <= prev_mem[rd_addr_i];
    end
  end
endmodule

[rtl/bba_engine.sv]
// Sequencer of the allocator: clearing pass, free-list heads, split and merge steps.
`include "buddy_block_allocator_macros.svh"
module bba_engine #(
  parameter int ORDER_COUNT = bba_pkg::DEF_ORDER_COUNT,
  parameter int UNIT_ORDER = bba_pkg::DEF_UNIT_ORDER
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic [3:0]    eff_i,
  input  logic [7:0]    header_i,
  input  logic          start_i,
  input  logic          kind_i,
  input  logic [15:0]   req_size_i,
  input  logic [14:0]   free_offset_i,
  output logic          idle_o,
  output logic          res_valid_o,
  input  logic          res_ack_i,
  output bba_pkg::res_t res_o
);
  import bba_pkg::*;

  localparam int UB = ADDR_BITS - UNIT_ORDER;
  localparam int LW = UB + 1;
  localparam int HW = $clog2(ORDER_COUNT);
  localparam logic [LW-1:0] NIL = {1'b1, {UB{1'b0}}};
  localparam logic [3:0] UO4 = 4'(UNIT_ORDER);
  localparam logic [4:0] UO5 = 5'(UNIT_ORDER);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_AZ     = 5'd2;
  localparam logic [4:0] S_ROUND  = 5'd3;
  localparam logic [4:0] S_SEARCH = 5'd4;
  localparam logic [4:0] S_UL1    = 5'd5;
  localparam logic [4:0] S_UL2    = 5'd6;
  localparam logic [4:0] S_SPLIT1 = 5'd7;
  localparam logic [4:0] S_SPLIT2 = 5'd8;
  localparam logic [4:0] S_F0     = 5'd9;
  localparam logic [4:0] S_FCHK   = 5'd10;
  localparam logic [4:0] S_BRD    = 5'd11;
  localparam logic [4:0] S_BCHK   = 5'd12;
  localparam logic [4:0] S_PUSH1  = 5'd13;
  localparam logic [4:0] S_PUSH2  = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  function automatic logic [HW-1:0] hsel(input logic [4:0] ord);
    return HW'(ord);
  endfunction

  logic [4:0]    state_q, state_d;
  logic [UB-1:0] cnt_q, cnt_d;
  logic          kind_q, kind_d;
  logic [16:0]   need_q, need_d;
  logic [15:0]   size_q, size_d;
  logic [14:0]   start_q, start_d;
  logic [4:0]    k_q, k_d, j_q, j_d;
  logic [3:0]    o_q, o_d;
  logic [UB-1:0] u_q, u_d, b_q, b_d, half_q, half_d;
  res_t          res_q, res_d;
  logic [LW-1:0] head_q [ORDER_COUNT];
  logic [LW-1:0] head_d [ORDER_COUNT];

  logic          rd_en;
  logic [UB-1:0] rd_addr;
  logic [4:0]    rd_meta;
  logic [UB:0]   rd_next, rd_prev;
  logic          meta_we, next_we, prev_we;
  logic [UB-1:0] meta_addr, next_addr, prev_addr;
  logic [4:0]    meta_wdata;
  logic [UB:0]   next_wdata, prev_wdata;

  logic [3:0]    rd_ord;
  logic          rd_free;
  logic [14:0]   f_start;
  logic [4:0]    jn;
  logic [UB-1:0] half;
  logic [UB-1:0] buddy;
  logic [LW-1:0] hj;
  logic [14:0]   omask;

  assign rd_ord = rd_meta[4:1];
  assign rd_free = rd_meta[0];
  assign f_start = free_offset_i - 15'(header_i);
  assign jn = j_q - 5'd1;
  assign half = u_q + (UB'(1) << (jn - UO5));
  assign buddy = u_q ^ (UB'(1) << (o_q - UO4));
  assign omask = (15'(1) << rd_ord) - 15'd1;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    kind_d = kind_q;
    need_d = need_q;
    size_d = size_q;
    start_d = start_q;
    k_d = k_q;
    j_d = j_q;
    o_d = o_q;
    u_d = u_q;
    b_d = b_q;
    half_d = half_q;
    res_d = res_q;
    head_d = head_q;
    hj = head_q[hsel(j_q)];
    rd_en = 1'b0;
    rd_addr = u_q;
    meta_we = 1'b0;
    meta_addr = u_q;
    meta_wdata = '0;
    next_we = 1'b0;
    next_addr = u_q;
    next_wdata = NIL;
    prev_we = 1'b0;
    prev_addr = u_q;
    prev_wdata = NIL;
    unique case (state_q)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_addr = cnt_q;
        meta_wdata = (cnt_q == '0) ? {eff_i, 1'b1} : 5'd0;
        next_we = 1'b1;
        next_addr = cnt_q;
        prev_we = 1'b1;
        prev_addr = cnt_q;
        if (cnt_q == '0) begin
          for (int i = 0; i < ORDER_COUNT; i++) begin
            head_d[i] = NIL;
          end
          head_d[hsel({1'b0, eff_i})] = '0;
        end
        cnt_d = cnt_q + UB'(1);
        if (&cnt_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          kind_d = kind_i;
          size_d = req_size_i;
          need_d = 17'(req_size_i) + 17'(header_i);
          k_d = 5'd1;
          start_d = f_start;
          res_d.offset = '0;
          if (kind_i == KIND_ALLOC) begin
            state_d = S_AZ;
          end else begin
            res_d.status = ST_NOT_OWNER;
            if (free_offset_i < 15'(header_i)) begin
              state_d = S_DONE;
            end else if ((16'(f_start) >> eff_i) != 16'd0) begin
              state_d = S_DONE;
            end else if (f_start[UNIT_ORDER-1:0] != '0) begin
              state_d = S_DONE;
            end else begin
              state_d = S_F0;
            end
          end
        end
      end
      S_AZ: begin
        if (size_q == 16'd0) begin
          res_d.status = ST_ZERO;
          state_d = S_DONE;
        end else begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (k_q <= {1'b0, eff_i} && need_q > (17'(1) << k_q)) begin
          k_d = k_q + 5'd1;
        end else if (k_q > {1'b0, eff_i}) begin
          res_d.status = ST_OOM;
          state_d = S_DONE;
        end else begin
          k_d = (k_q < UO5) ? UO5 : k_q;
          j_d = (k_q < UO5) ? UO5 : k_q;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (j_q > {1'b0, eff_i}) begin
          res_d.status = ST_OOM;
          state_d = S_DONE;
        end else if (!hj[UB]) begin
          u_d = hj[UB-1:0];
          b_d = hj[UB-1:0];
          rd_en = 1'b1;
          rd_addr = hj[UB-1:0];
          state_d = S_UL1;
        end else begin
          j_d = j_q + 5'd1;
        end
      end
      S_UL1: begin
        if (!rd_prev[UB]) begin
          next_we = 1'b1;
          next_addr = rd_prev[UB-1:0];
          next_wdata = rd_next;
        end else begin
          head_d[hsel({1'b0, rd_ord})] = rd_next;
        end
        if (!rd_next[UB]) begin
          prev_we = 1'b1;
          prev_addr = rd_next[UB-1:0];
          prev_wdata = rd_prev;
        end
        meta_we = 1'b1;
        meta_addr = b_q;
        meta_wdata = {rd_ord, 1'b0};
        state_d = S_UL2;
      end
      S_UL2: begin
        next_we = 1'b1;
        next_addr = b_q;
        prev_we = 1'b1;
        prev_addr = b_q;
        if (kind_q == KIND_ALLOC) begin
          state_d = S_SPLIT1;
        end else begin
          meta_we = 1'b1;
          meta_addr = (b_q < u_q) ? b_q : u_q;
          meta_wdata = {o_q + 4'd1, 1'b0};
          if (b_q < u_q) begin
            u_d = b_q;
          end
          o_d = o_q + 4'd1;
          state_d = S_BRD;
        end
      end
      S_SPLIT1: begin
        if (j_q > k_q) begin
          meta_we = 1'b1;
          meta_addr = half;
          meta_wdata = {jn[3:0], 1'b1};
          next_we = 1'b1;
          next_addr = half;
          next_wdata = head_q[hsel(jn)];
          prev_we = 1'b1;
          prev_addr = half;
          half_d = half;
          j_d = jn;
          state_d = S_SPLIT2;
        end else begin
          meta_we = 1'b1;
          meta_addr = u_q;
          meta_wdata = {k_q[3:0], 1'b0};
          res_d.status = ST_OK;
          res_d.offset = {u_q, {UNIT_ORDER{1'b0}}} + 15'(header_i);
          state_d = S_DONE;
        end
      end
      S_SPLIT2: begin
        if (!hj[UB]) begin
          prev_we = 1'b1;
          prev_addr = hj[UB-1:0];
          prev_wdata = {1'b0, half_q};
        end
        head_d[hsel(j_q)] = {1'b0, half_q};
        state_d = S_SPLIT1;
      end
      S_F0: begin
        u_d = start_q[14:UNIT_ORDER];
        rd_en = 1'b1;
        rd_addr = start_q[14:UNIT_ORDER];
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (rd_free || rd_ord < UO4 || rd_ord > eff_i || (start_q & omask) != 15'd0) begin
          state_d = S_DONE;
        end else begin
          o_d = rd_ord;
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        if (o_q < eff_i) begin
          b_d = buddy;
          rd_en = 1'b1;
          rd_addr = buddy;
          state_d = S_BCHK;
        end else begin
          state_d = S_PUSH1;
        end
      end
      S_BCHK: begin
        if (rd_free && rd_ord == o_q) begin
          state_d = S_UL1;
        end else begin
          state_d = S_PUSH1;
        end
      end
      S_PUSH1: begin
        meta_we = 1'b1;
        meta_addr = u_q;
        meta_wdata = {o_q, 1'b1};
        next_we = 1'b1;
        next_addr = u_q;
        next_wdata = head_q[hsel({1'b0, o_q})];
        prev_we = 1'b1;
        prev_addr = u_q;
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        if (!head_q[hsel({1'b0, o_q})][UB]) begin
          prev_we = 1'b1;
          prev_addr = head_q[hsel({1'b0, o_q})][UB-1:0];
          prev_wdata = {1'b0, u_q};
        end
        head_d[hsel({1'b0, o_q})] = {1'b0, u_q};
        res_d.status = ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (clear_i) begin
      state_d = S_CLEAR;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head_q[i] <= NIL;
      end
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    need_q <= need_d;
    size_q <= size_d;
    start_q <= start_d;
    k_q <= k_d;
    j_q <= j_d;
    o_q <= o_d;
    u_q <= u_d;
    b_q <= b_d;
    half_q <= half_d;
    res_q <= res_d;
  end

  bba_desc_mem #(
    .UB(UB)
  ) u_mem (
    .clk_i        (clk_i),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_meta_o    (rd_meta),
    .rd_next_o    (rd_next),
    .rd_prev_o    (rd_prev),
    .meta_we_i    (meta_we),
    .meta_addr_i  (meta_addr),
    .meta_wdata_i (meta_wdata),
    .next_we_i    (next_we),
    .next_addr_i  (next_addr),
    .next_wdata_i (next_wdata),
    .prev_we_i    (prev_we),
    .prev_addr_i  (prev_addr),
    .prev_wdata_i (prev_wdata)
  );

  assign idle_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o = res_q;

  `BBA_ASSERT(a_done_holds, (state_q == S_DONE && !res_ack_i && !clear_i) |=> state_q == S_DONE)
  `BBA_ASSERT(a_no_read_write_mix, rd_en |-> !meta_we && !next_we && !prev_we)
  `BBA_ASSERT(a_cnt_still, (state_q != S_CLEAR && !clear_i) |=> $stable(cnt_q))
endmodule

[rtl/buddy_block_allocator.sv]
// Top level of the buddy block allocator: register port, transfer handshakes, engine.
// After reset and after every register write the block runs a clearing pass over the
// descriptor memory of 2^(15-UNIT_ORDER) units, one unit a cycle, and takes no item
// meanwhile. An item then runs through the order-by-order sequencer, which reads the
// descriptor memory through its single read port: an allocate rounds the size order by
// order, searches the free lists order by order, unlinks the block and splits it level by
// level; a free checks the block, merges it with each free buddy and pushes the block. One
// result is delivered per item, in order, and no new item is taken until it is handed on.
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator #(
  parameter int ORDER_COUNT = bba_pkg::DEF_ORDER_COUNT,
  parameter int UNIT_ORDER = bba_pkg::DEF_UNIT_ORDER
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] req_size_i,
  input  logic [14:0] free_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [14:0] block_offset_o
);
  import bba_pkg::*;

  localparam int MAXO = (ORDER_COUNT - 1 > 15) ? 15 : ORDER_COUNT - 1;

  logic [3:0]  pool_order_q;
  logic [7:0]  header_q;
  logic        cfg_wr;
  logic [3:0]  capped;
  logic [3:0]  eff;
  logic        idle;
  logic        res_valid;
  logic        res_ack;
  res_t        res;
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [14:0] offset_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEADER) ? {24'd0, header_q} : {28'd0, pool_order_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_order_q <= POOL_ORDER_RST;
      header_q <= HEADER_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POOL_ORDER) begin
        pool_order_q <= pwdata[3:0];
      end else begin
        header_q <= pwdata[7:0];
      end
    end
  end

  assign capped = (pool_order_q > 4'(MAXO)) ? 4'(MAXO) : pool_order_q;
  assign eff = (capped < 4'(UNIT_ORDER)) ? 4'(UNIT_ORDER) : capped;

  assign in_ready_o = idle;
  assign res_ack = res_valid && (!out_valid_q || out_ready_i);

  bba_engine #(
    .ORDER_COUNT(ORDER_COUNT),
    .UNIT_ORDER (UNIT_ORDER)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_wr),
    .eff_i        (eff),
    .header_i     (header_q),
    .start_i      (in_valid_i && idle),
    .kind_i       (kind_i),
    .req_size_i   (req_size_i),
    .free_offset_i(free_offset_i),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_ack_i    (res_ack),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      status_q <= res.status;
      offset_q <= res.offset;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign block_offset_o = offset_q;

  `BBA_ASSERT(a_out_hold, (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(offset_q))
  `BBA_ASSERT(a_no_accept_busy, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `BBA_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o)
endmodule
